// ===== rtl/rect_vs_tile_map_collision_assert.svh =====
// Assertion macros for the rectangle versus tile map collision block.
`ifndef RECT_VS_TILE_MAP_COLLISION_ASSERT_SVH
`define RECT_VS_TILE_MAP_COLLISION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define RVTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rvtm: assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define RVTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rvtm: assertion failed");

`else

`define RVTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RVTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rvtm_pkg.sv =====
// Shared types and constants of the rectangle versus tile map collision block.
package rvtm_pkg;

	// Map geometry
	localparam int MAP_ROWS   = 32;
	localparam int MAP_COLS   = 128;
	localparam int TILE_SHIFT = 5;
	localparam int ROW_W      = $clog2(MAP_ROWS);
	localparam int COL_W      = $clog2(MAP_COLS);

	// Configuration registers
	localparam int ROWS_CFG_W = 6;
	localparam int COLS_CFG_W = 8;
	localparam int ROWS_RESET = 20;
	localparam int COLS_RESET = 100;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// Signed pixel/tile arithmetic: 16-bit coordinate plus 12-bit size, with headroom
	localparam int COORD_W = 18;

	// Front to back queue; depth is a power of two so the pointers wrap by themselves
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [COL_W-1:0]    col_t;
	typedef logic [MAP_COLS-1:0] col_mask_t;

	localparam col_mask_t ALL_COLS = '1;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	// One classified transaction, as it waits in the queue
	typedef struct packed {
		kind_t     kind;
		logic      wr_en;    // write lands inside the map
		row_t      wr_row;
		col_t      wr_col;
		logic      wr_solid;
		logic      q_empty;  // clamped range is empty, answer is no hit
		row_t      r0;
		row_t      r1;
		col_mask_t mask;     // columns c0..c1 of the query
	} item_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_READ,
		ST_WR_WRITE,
		ST_Q_READ,
		ST_Q_CHECK,
		ST_DONE
	} back_state_t;

endpackage

// ===== rtl/rvtm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rvtm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rvtm_front.sv =====
// Front end: accepts input transactions and classifies them into queue items.
module rvtm_front
	import rvtm_pkg::*;
(
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [4:0]             tile_row,
	input  logic [6:0]             tile_col,
	input  logic [15:0]            tile_value,
	input  logic signed [15:0]     rect_x,
	input  logic signed [15:0]     rect_y,
	input  logic [11:0]            rect_w,
	input  logic [11:0]            rect_h,
	input  logic [ROWS_CFG_W-1:0]  rows_in_use,
	input  logic [COLS_CFG_W-1:0]  cols_in_use,
	input  logic                   q_full,
	input  back_status_t           status,
	output logic                   q_push,
	output item_t                  q_item
);

	logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
	logic signed [COORD_W-1:0] c_lo_t, c_hi_t, r_lo_t, r_hi_t;
	logic signed [COORD_W-1:0] c_lim, r_lim;
	logic signed [COORD_W-1:0] c0, c1, r0, r1;
	logic [COORD_W-1:0]        c_n, r_n;
	logic                      col_ok, row_ok;
	col_mask_t                 lo_mask, hi_mask;

	assign in_stall = q_full | status.clearing;
	assign q_push   = in_valid & ~in_stall;

	// Edges in pixels, floor-divided to tiles by arithmetic shift
	always_comb begin
		x_lo   = COORD_W'(rect_x);
		x_hi   = x_lo + signed'(COORD_W'(rect_w));
		y_lo   = COORD_W'(rect_y);
		y_hi   = y_lo + signed'(COORD_W'(rect_h));
		c_lo_t = x_lo >>> TILE_SHIFT;
		c_hi_t = x_hi >>> TILE_SHIFT;
		r_lo_t = y_lo >>> TILE_SHIFT;
		r_hi_t = y_hi >>> TILE_SHIFT;
	end

	// Counts in use are capped at the map size; zero in use gives a limit of -1
	always_comb begin
		c_n   = (COORD_W'(cols_in_use) > COORD_W'(MAP_COLS)) ? COORD_W'(MAP_COLS)
		                                                      : COORD_W'(cols_in_use);
		r_n   = (COORD_W'(rows_in_use) > COORD_W'(MAP_ROWS)) ? COORD_W'(MAP_ROWS)
		                                                      : COORD_W'(rows_in_use);
		c_lim = signed'(c_n) - signed'(COORD_W'(1));
		r_lim = signed'(r_n) - signed'(COORD_W'(1));

		c0 = c_lo_t[COORD_W-1] ? '0 : c_lo_t;
		r0 = r_lo_t[COORD_W-1] ? '0 : r_lo_t;
		c1 = (c_hi_t > c_lim) ? c_lim : c_hi_t;
		r1 = (r_hi_t > r_lim) ? r_lim : r_hi_t;

		col_ok = (c0 <= c1);
		row_ok = (r0 <= r1);
	end

	// Column window as a bit mask over one map row
	always_comb begin
		lo_mask = ALL_COLS << c0[COL_W-1:0];
		hi_mask = ALL_COLS >> (COL_W'(MAP_COLS - 1) - c1[COL_W-1:0]);
	end

	always_comb begin
		q_item          = '0;
		q_item.kind     = kind_t'(kind);
		q_item.wr_en    = (int'(tile_row) < MAP_ROWS) && (int'(tile_col) < MAP_COLS);
		q_item.wr_row   = ROW_W'(tile_row);
		q_item.wr_col   = COL_W'(tile_col);
		q_item.wr_solid = (tile_value != '0);
		q_item.q_empty  = ~(col_ok & row_ok);
		q_item.r0       = r0[ROW_W-1:0];
		q_item.r1       = r1[ROW_W-1:0];
		q_item.mask     = lo_mask & hi_mask;
	end

endmodule

// ===== rtl/rvtm_queue.sv =====
// Short queue of classified items between front end and back end.
module rvtm_queue
	import rvtm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/rvtm_back.sv =====
// Back end: clears the map, applies tile writes, scans query rows, holds the result.
`include "rect_vs_tile_map_collision_assert.svh"

module rvtm_back
	import rvtm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  item_t        q_item,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic         hit,
	output back_status_t status
);

	back_state_t state_q, state_d;
	row_t        clr_row_q;
	item_t       work_q;
	row_t        row_q;
	logic        acc_q;
	logic        out_valid_q, out_hit_q;

	logic        ram_we, ram_re;
	row_t        ram_waddr, ram_raddr;
	col_mask_t   ram_wdata, ram_rdata, bit_sel;
	logic        row_hit, last_row, last_clear, out_free, out_load;

	rvtm_ram #(
		.WIDTH(MAP_COLS),
		.DEPTH(MAP_ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign row_hit    = |(ram_rdata & work_q.mask);
	assign last_row   = (row_q == work_q.r1);
	assign last_clear = (clr_row_q == ROW_W'(MAP_ROWS - 1));
	assign bit_sel    = col_mask_t'(1) << work_q.wr_col;
	assign out_free   = ~out_valid_q | ~out_stall;
	assign out_load   = (state_q == ST_DONE) & out_free;

	assign out_valid       = out_valid_q;
	assign hit             = out_hit_q;
	assign status.clearing = (state_q == ST_CLEAR);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				state_d = last_clear ? ST_IDLE : ST_CLEAR;
			end
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.kind == KIND_WRITE) begin
						state_d = q_item.wr_en ? ST_WR_READ : ST_IDLE;
					end else begin
						state_d = q_item.q_empty ? ST_DONE : ST_Q_READ;
					end
				end
			end
			ST_WR_READ:  state_d = ST_WR_WRITE;
			ST_WR_WRITE: state_d = ST_IDLE;
			ST_Q_READ:   state_d = ST_Q_CHECK;
			ST_Q_CHECK: begin
				if (row_hit || last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: queue pop and map port
	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = work_q.wr_row;
		ram_wdata = (ram_rdata & ~bit_sel) | (work_q.wr_solid ? bit_sel : '0);
		ram_re    = 1'b0;
		ram_raddr = row_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_row_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				q_pop = q_valid;
			end
			ST_WR_READ: begin
				ram_re    = 1'b1;
				ram_raddr = work_q.wr_row;
			end
			ST_WR_WRITE: begin
				ram_we = 1'b1;
			end
			ST_Q_READ: begin
				ram_re = 1'b1;
			end
			ST_Q_CHECK: begin
				// fetch the following row while this one is checked
				ram_re    = 1'b1;
				ram_raddr = row_q + 1'b1;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_row_q <= clr_row_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_item;
			row_q  <= q_item.r0;
			acc_q  <= 1'b0;
		end else if (state_q == ST_Q_CHECK) begin
			row_q <= row_q + 1'b1;
			acc_q <= row_hit;
		end
		if (out_load) begin
			out_hit_q <= acc_q;
		end
	end

	`RVTM_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == ST_Q_CHECK, (row_q >= work_q.r0) && (row_q <= work_q.r1))
	`RVTM_ASSERT_NOW(a_no_write_in_scan, clk, arst_n, (state_q == ST_Q_READ) || (state_q == ST_Q_CHECK), !ram_we)
	`RVTM_ASSERT_NEXT(a_done_delivers, clk, arst_n, out_load, out_valid_q && (out_hit_q == $past(acc_q)))
	`RVTM_ASSERT_NOW(a_no_result_in_clear, clk, arst_n, status.clearing, !out_valid_q && !q_pop)

endmodule

// ===== rtl/rect_vs_tile_map_collision.sv =====
// Top level of the rectangle versus tile map collision block.
//
//  channel  direction  handshake                    payload
//  cfg      in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//  in       in         in_valid / in_stall          kind, tile_*, rect_*
//  out      out        out_valid / out_stall        hit
//
// In the back end a tile write goes pop, read row, write row. A query goes pop,
// read row, then checks the tile rows in turn (stops at the first solid row) and
// ends in the done state; an empty clamped range goes from pop straight to done.
// After reset the back end sweeps the map clean, one row per cycle, all MAP_ROWS
// (32) rows; in_stall stays high meanwhile, config writes still land.
// The queue lets the front take transactions while a result waits on out_stall.
module rect_vs_tile_map_collision
	import rvtm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// input transactions
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [4:0]          tile_row,
	input  logic [6:0]          tile_col,
	input  logic [15:0]         tile_value,
	input  logic signed [15:0]  rect_x,
	input  logic signed [15:0]  rect_y,
	input  logic [11:0]         rect_w,
	input  logic [11:0]         rect_h,
	// result transactions
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit
);

	logic [ROWS_CFG_W-1:0] rows_q;
	logic [COLS_CFG_W-1:0] cols_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	logic                  q_push, q_full, q_pop, q_valid;
	item_t                 push_item, head_item;
	back_status_t          status;

	// Config registers; word address selects the register, pready tied high
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_CFG_W'(ROWS_RESET);
			cols_q <= COLS_CFG_W'(COLS_RESET);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROWS: rows_q <= pwdata[ROWS_CFG_W-1:0];
				REG_COLS: cols_q <= pwdata[COLS_CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROWS: prdata = APB_DW'(rows_q);
			REG_COLS: prdata = APB_DW'(cols_q);
		endcase
	end

	// Front: accept and classify (clamped tile ranges, column mask)
	rvtm_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.tile_row   (tile_row),
		.tile_col   (tile_col),
		.tile_value (tile_value),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.rows_in_use(rows_q),
		.cols_in_use(cols_q),
		.q_full     (q_full),
		.status     (status),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	rvtm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_item (head_item)
	);

	// Back: map memory, row scan, result register
	rvtm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (head_item),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit),
		.status   (status)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the rectangle versus tile map collision block.
module testbench;
	import rvtm_pkg::*;

	// Drain time after the last expected result: a query can scan every map row
	// and the two-entry queue may hold one more behind it.
	localparam int DRAIN_CYCLES = 100;
	// Generous cycle limit. Slowest run: ~1400 transactions, each up to a full row
	// scan plus long receiver stalls, the clearing sweep, and phase drains.
	localparam int CYCLE_LIMIT  = 600000;
	localparam int NUM_PHASES   = 9;
	localparam int PHASE_ITEMS  = 145;

	// One input transaction, at the block's field widths
	typedef struct {
		kind_t              kind;
		bit [4:0]           row;
		bit [6:0]           col;
		bit [15:0]          value;
		bit signed [15:0]   x;
		bit signed [15:0]   y;
		bit [11:0]          w;
		bit [11:0]          h;
	} map_tx_t;

	// Scoreboard: shadow solid map, shadow registers, and pending hit answers
	class collision_scoreboard;
		bit solid [MAP_ROWS][MAP_COLS];
		int rows_in_use;
		int cols_in_use;
		bit expected_hits[$];
		int mismatches;

		function new();
			foreach (solid[r, c])
				solid[r][c] = 1'b0;
			rows_in_use = ROWS_RESET;
			cols_in_use = COLS_RESET;
			mismatches  = 0;
		endfunction

		function void set_reg(reg_idx_t idx, int value);
			case (idx)
				REG_ROWS: begin
					rows_in_use = value & ((1 << ROWS_CFG_W) - 1);
				end
				REG_COLS: begin
					cols_in_use = value & ((1 << COLS_CFG_W) - 1);
				end
			endcase
		endfunction

		// Pixel span to clamped tile span; returns 1 when the span is not empty
		function bit tile_span(int lo_px, int hi_px, int count, int limit,
				output int lo, output int hi);
			int n;
			n  = (count > limit) ? limit : count;
			lo = lo_px >>> TILE_SHIFT;   // floor, also for negative pixels
			hi = hi_px >>> TILE_SHIFT;
			if (lo < 0)
				lo = 0;
			if (hi > n - 1)
				hi = n - 1;
			return lo <= hi;
		endfunction

		function bit predict_hit(map_tx_t t);
			int c0, c1, r0, r1;
			bit cols_ok, rows_ok;
			cols_ok = tile_span(int'(t.x), int'(t.x) + int'(t.w), cols_in_use, MAP_COLS,
				c0, c1);
			rows_ok = tile_span(int'(t.y), int'(t.y) + int'(t.h), rows_in_use, MAP_ROWS,
				r0, r1);
			if (!(cols_ok && rows_ok))
				return 1'b0;
			for (int r = r0; r <= r1; r++)
				for (int c = c0; c <= c1; c++)
					if (solid[r][c])
						return 1'b1;
			return 1'b0;
		endfunction

		function void note_transaction(map_tx_t t);
			if (t.kind == KIND_WRITE) begin
				if (t.row < MAP_ROWS && t.col < MAP_COLS)
					solid[t.row][t.col] = (t.value > 0);
			end else begin
				expected_hits.push_back(predict_hit(t));
			end
		endfunction

		task report_mismatch(string msg);
			$display("mismatch @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_hit(logic got);
			bit want;
			if (expected_hits.size() == 0) begin
				report_mismatch($sformatf("unexpected result, hit=%0b", got));
			end else begin
				want = expected_hits.pop_front();
				if (got !== want)
					report_mismatch($sformatf("hit=%0b, expected %0b", got, want));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [4:0]         tile_row;
	logic [6:0]         tile_col;
	logic [15:0]        tile_value;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [11:0]        rect_w;
	logic [11:0]        rect_h;
	logic               out_valid;
	logic               out_stall;
	logic               hit;

	collision_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count = 0;

	rect_vs_tile_map_collision u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.tile_row   (tile_row),
		.tile_col   (tile_col),
		.tile_value (tile_value),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** rect_vs_tile_map_collision: FAILED **");
			$finish;
		end
	end

	// Result side: stall decided at the falling edge, transaction taken at the
	// rising edge when valid is high and our stall is low.
	initial begin
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_idle_pct);
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_hit(hit);
		end
	end

	// Register write: setup cycle, then access cycle until pready
	task apb_write(reg_idx_t idx, int value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one transaction; returns after the edge where it is accepted.
	// in_valid stays high afterwards, so back-to-back transactions see no gap.
	task send_tx(map_tx_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		kind       <= t.kind;
		tile_row   <= t.row;
		tile_col   <= t.col;
		tile_value <= t.value;
		rect_x     <= t.x;
		rect_y     <= t.y;
		rect_w     <= t.w;
		rect_h     <= t.h;
		do @(posedge clk); while (in_stall);
		sb.note_transaction(t);
	endtask

	task send_write(int row, int col, int value);
		map_tx_t t;
		t = '{KIND_WRITE, 5'(row), 7'(col), 16'(value), 16'sd0, 16'sd0, 12'd0, 12'd0};
		send_tx(t);
	endtask

	task send_query(int x, int y, int w, int h);
		map_tx_t t;
		t = '{KIND_QUERY, 5'd0, 7'd0, 16'd0, 16'(x), 16'(y), 12'(w), 12'(h)};
		send_tx(t);
	endtask

	// Wait out every pending answer, then let the back end settle
	task wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random transaction. All fields start fully random so every bit toggles;
	// most are then shaped to land on or near the map in use.
	function map_tx_t rand_tx();
		map_tx_t t;
		int sel, rows, cols;
		rows = (sb.rows_in_use > MAP_ROWS) ? MAP_ROWS : sb.rows_in_use;
		cols = (sb.cols_in_use > MAP_COLS) ? MAP_COLS : sb.cols_in_use;
		if (rows == 0) rows = MAP_ROWS;
		if (cols == 0) cols = MAP_COLS;
		t.row   = 5'($urandom);
		t.col   = 7'($urandom);
		t.value = 16'($urandom);
		t.x     = 16'($urandom);
		t.y     = 16'($urandom);
		t.w     = 12'($urandom);
		t.h     = 12'($urandom);
		sel     = $urandom_range(99);
		if (sel < 35) begin
			t.kind = KIND_WRITE;
			if ($urandom_range(3) != 0) begin
				t.row = 5'($urandom_range(rows - 1));
				t.col = 7'($urandom_range(cols - 1));
			end
			// half the writes clear, so the map stays sparse and hits stay mixed
			if ($urandom_range(1) == 0)
				t.value = 16'd0;
		end else begin
			t.kind = KIND_QUERY;
			if (sel < 92) begin
				t.x = 16'($urandom_range(cols * 32 + 96) - 64);
				t.y = 16'($urandom_range(rows * 32 + 96) - 64);
				t.w = 12'($urandom_range(80));
				t.h = 12'($urandom_range(80));
			end
		end
		return t;
	endfunction

	initial begin
		int rows_cfg[NUM_PHASES];
		int cols_cfg[NUM_PHASES];

		sb          = new();
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		kind        = KIND_WRITE;
		tile_row    = '0;
		tile_col    = '0;
		tile_value  = '0;
		rect_x      = '0;
		rect_y      = '0;
		rect_w      = '0;
		rect_h      = '0;
		out_stall   = 1'b0;
		send_idle_pct = 23;
		recv_idle_pct = 88;

		// Register settings per phase; phase 0 runs on reset values.
		// Zero, one, the map size and above-the-map values all appear.
		rows_cfg = '{ROWS_RESET, 32, 1, 0, 63, 12, 0, 0, 32};
		cols_cfg = '{COLS_RESET, 128, 1, 77, 0, 255, 0, 0, 128};
		rows_cfg[6] = $urandom_range(63);
		cols_cfg[6] = $urandom_range(255);
		rows_cfg[7] = $urandom_range(1, 32);
		cols_cfg[7] = $urandom_range(1, 128);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed transactions on the reset map (20 rows, 100 cols in use)
		send_query(0, 0, 0, 0);                   // empty map, no hit
		send_write(0, 0, 1);                      // smallest solid value
		send_write(31, 127, 65535);               // far corner, beyond map in use
		send_write(19, 99, 16'h8000);             // last tile in use
		send_query(0, 0, 0, 0);                   // top-left tile
		send_query(-1, -1, 1, 1);                 // negative edge floors to -1, clamps to 0
		send_query(-33, -33, 32, 32);             // ends at -1 -> tile -1, empty range
		send_query(-32768, -32768, 4095, 4095);   // wholly left of and above the map
		send_query(32767, 32767, 4095, 4095);     // wholly right of and below the map
		send_query(99 * 32, 19 * 32, 0, 0);       // last tile in use
		send_query(127 * 32, 31 * 32, 31, 31);    // solid, but outside the map in use
		send_query(1000, 1000, 4095, 4095);       // clamped down to last row/col in use
		send_query(32, 32, 31, 31);               // one empty tile, no hit
		send_write(0, 0, 0);                      // clear the top-left tile again
		send_query(-32768, -32768, 4095, 4095);
		send_query(0, 0, 31, 31);                 // cleared tile, no hit
		send_query(-32768, 0, 4095, 31);          // x range ends below zero
		send_write(5, 7, 2);
		send_query(7 * 32 - 1, 5 * 32 - 1, 1, 1); // reaches the tile by one pixel
		send_query(7 * 32 - 2, 5 * 32 - 2, 1, 1); // stops one pixel short
		send_write(5, 7, 0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// sender and receiver idling swap after three phases, then both stop
			case (p / 3)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// registers change only with the pipe empty; this also gives the
			// sender a full pause until every answer is back
			if (p != 0) begin
				wait_drained();
				apb_write(REG_ROWS, rows_cfg[p]);
				apb_write(REG_COLS, cols_cfg[p]);
				// after each register change, also with a zero-sized map in use: touch both extremes of a query directly
				send_query(0, 0, 4095, 4095);
				send_query(-32768, -32768, 0, 0);
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_tx(rand_tx());
		end

		wait_drained();
		if (sb.mismatches == 0) begin
			$display("** rect_vs_tile_map_collision: PASSED **");
		end else begin
			$display("** rect_vs_tile_map_collision: FAILED **");
		end
		$finish;
	end

endmodule

// ===== rect_vs_tile_map_collision.f =====
+incdir+rtl
rtl/rvtm_pkg.sv
rtl/rvtm_ram.sv
rtl/rvtm_front.sv
rtl/rvtm_queue.sv
rtl/rvtm_back.sv
rtl/rect_vs_tile_map_collision.sv
verif/testbench.sv
